// ===== src/lpt_pkg.sv =====
// Shared constants for the linear-probe hash table core.
// Depends on nothing; used by the core and its port checker.
package lpt_pkg;

  localparam int TABLE_ENTRIES_DEF = 4096;
  localparam int PROBE_LIMIT_DEF   = 16;

  localparam int KEY_W      = 64;
  localparam int VAL_W      = 16;
  localparam int HASH_SHIFT = 16;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

endpackage

// ===== src/linear_probe_table_64bit_key_core.sv =====
// Open-addressing hash table with linear probing, 64-bit keys, 16-bit values.
// Depends on lpt_pkg for widths, mode codes and parameter defaults.
//
// Usage:
//   Request channel in_valid/in_ready carries mode, key and value; mode selects
//   insert-or-update or lookup. Result channel out_valid/out_ready carries hit
//   and found_value, one result per request, in request order.
//   Key and value sit in two single-port-read memories of TABLE_ENTRIES
//   entries. A request probes up to PROBE_LIMIT consecutive slots, one memory
//   read a cycle, and stops at the first qualifying slot; an insert writes
//   back into that slot in the same cycle that it checks it.
//   With a power-of-two table a request goes straight to probing: each probe
//   reads a slot into the read register, is checked there, and the result
//   passes through S_DONE into the output register. A table of any other size
//   first reduces the key hash modulo TABLE_ENTRIES in S_HASH, two bits a cycle.
//   One request is in work at a time; the next is accepted as soon as the
//   previous result is in the output register, even if it is not yet taken.
//   Reset: both memories are cleared by a pass over all TABLE_ENTRIES entries
//   (4096 by default), one entry a cycle, with in_ready low.
//   Receiver stall: the result holds in the output register; a finished
//   request waits in S_DONE until the register frees, and in_ready stays low.
module linear_probe_table_64bit_key_core #(
  parameter int TABLE_ENTRIES = lpt_pkg::TABLE_ENTRIES_DEF,
  parameter int PROBE_LIMIT   = lpt_pkg::PROBE_LIMIT_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      mode,
  input  logic [lpt_pkg::KEY_W-1:0] key,
  input  logic [lpt_pkg::VAL_W-1:0] value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      hit,
  output logic [lpt_pkg::VAL_W-1:0] found_value
);

  localparam int AW     = $clog2(TABLE_ENTRIES);
  localparam int CW     = $clog2(PROBE_LIMIT + 1);
  localparam bit POW2   = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
  localparam int DIGITS = lpt_pkg::KEY_W / 2;
  localparam int DW     = $clog2(DIGITS);

  localparam logic [AW-1:0] LAST    = AW'(TABLE_ENTRIES - 1);
  localparam logic [AW+1:0] N1      = (AW + 2)'(TABLE_ENTRIES);
  localparam logic [AW+1:0] N2      = (AW + 2)'(2 * TABLE_ENTRIES);
  localparam logic [AW+1:0] N3      = (AW + 2)'(3 * TABLE_ENTRIES);
  localparam logic [CW-1:0] PL      = CW'(PROBE_LIMIT);
  localparam logic [DW-1:0] DIG_END = DW'(DIGITS - 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HASH  = 5'b00100,
    S_PROBE = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;

  logic [lpt_pkg::KEY_W-1:0] key_mem [TABLE_ENTRIES];
  logic [lpt_pkg::VAL_W-1:0] val_mem [TABLE_ENTRIES];

  logic [AW-1:0]             clr_addr;
  logic                      req_mode;
  logic [lpt_pkg::KEY_W-1:0] req_key;
  logic [lpt_pkg::VAL_W-1:0] req_value;
  logic [lpt_pkg::KEY_W-1:0] hash_word;
  logic [AW-1:0]             hash_rem;
  logic [DW-1:0]             digit_cnt;
  logic [AW-1:0]             issue_slot;
  logic [CW-1:0]             issue_cnt;
  logic [AW-1:0]             rd_slot;
  logic                      rd_valid;
  logic [lpt_pkg::KEY_W-1:0] rd_key;
  logic [lpt_pkg::VAL_W-1:0] rd_value;
  logic                      res_hit;
  logic [lpt_pkg::VAL_W-1:0] res_value;

  logic [lpt_pkg::KEY_W-1:0] hash_in;
  logic [AW+1:0]             hash_wide;
  logic [AW+1:0]             hash_sub;
  logic [AW-1:0]             rem_next;
  logic [AW-1:0]             slot_step;
  logic                      issue_go;
  logic                      probe_hit;
  logic                      probe_miss;
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [lpt_pkg::KEY_W-1:0] mem_wkey;
  logic [lpt_pkg::VAL_W-1:0] mem_wval;

  assign in_ready = (state == S_IDLE);
  assign hash_in  = key ^ (key >> lpt_pkg::HASH_SHIFT);

  always_comb begin
    hash_wide = {hash_rem, hash_word[lpt_pkg::KEY_W-1 -: 2]};
    if (hash_wide >= N3) begin
      hash_sub = N3;
    end else if (hash_wide >= N2) begin
      hash_sub = N2;
    end else if (hash_wide >= N1) begin
      hash_sub = N1;
    end else begin
      hash_sub = '0;
    end
    rem_next = AW'(hash_wide - hash_sub);
  end

  assign slot_step  = (issue_slot == LAST) ? '0 : issue_slot + 1'b1;
  assign issue_go   = (state == S_PROBE) && (issue_cnt < PL);
  assign probe_hit  = rd_valid && ((rd_key == req_key) ||
                      ((req_mode == lpt_pkg::MODE_INSERT) && (rd_key == '0)));
  assign probe_miss = !rd_valid && (issue_cnt == PL);

  assign mem_we    = (state == S_CLEAR) ||
                     ((state == S_PROBE) && probe_hit && (req_mode == lpt_pkg::MODE_INSERT));
  assign mem_waddr = (state == S_CLEAR) ? clr_addr : rd_slot;
  assign mem_wkey  = (state == S_CLEAR) ? '0 : req_key;
  assign mem_wval  = (state == S_CLEAR) ? '0 : req_value;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[mem_waddr] <= mem_wkey;
      val_mem[mem_waddr] <= mem_wval;
    end
    if (issue_go) begin
      rd_key   <= key_mem[issue_slot];
      rd_value <= val_mem[issue_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_DONE) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= (clr_addr == LAST) ? '0 : clr_addr + 1'b1;
          if (clr_addr == LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req_mode   <= mode;
            req_key    <= key;
            req_value  <= value;
            hash_word  <= hash_in;
            hash_rem   <= '0;
            digit_cnt  <= '0;
            issue_slot <= hash_in[AW-1:0];
            issue_cnt  <= '0;
            rd_valid   <= 1'b0;
            state      <= POW2 ? S_PROBE : S_HASH;
          end
        end
        S_HASH: begin
          hash_word <= hash_word << 2;
          hash_rem  <= rem_next;
          digit_cnt <= digit_cnt + 1'b1;
          if (digit_cnt == DIG_END) begin
            issue_slot <= rem_next;
            state      <= S_PROBE;
          end
        end
        S_PROBE: begin
          rd_valid <= issue_go;
          if (issue_go) begin
            rd_slot    <= issue_slot;
            issue_slot <= slot_step;
            issue_cnt  <= issue_cnt + 1'b1;
          end
          if (probe_hit) begin
            res_hit   <= 1'b1;
            res_value <= (req_mode == lpt_pkg::MODE_LOOKUP) ? rd_value : '0;
            state     <= S_DONE;
          end else if (probe_miss) begin
            res_hit   <= 1'b0;
            res_value <= '0;
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            hit         <= res_hit;
            found_value <= res_value;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

endmodule

// ===== src/lpt_checker.sv =====
// Port-level checker for the linear-probe hash table core, bound to its top.
// Depends on lpt_pkg for field widths.
module lpt_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      hit,
  input logic [lpt_pkg::VAL_W-1:0] found_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(found_value))
    else $error("result changed while stalled");

  a_value_needs_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && (found_value != '0) |-> hit)
    else $error("nonzero value without hit");

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one in work");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && !in_ready)
    else $error("channels active right after reset");

endmodule

bind linear_probe_table_64bit_key_core lpt_checker u_lpt_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .hit         (hit),
  .found_value (found_value)
);
